// ===== rtl/core/rgg_pkg.sv =====
// Shared constants, configuration and pipeline types for the gate generator.
package rgg_pkg;

   localparam int CHANNELS   = 16;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int COUNT_BITS = 21;
   localparam int END_BITS   = 13;
   localparam int MV_W       = 15;
   localparam int TICK_W     = 20;
   localparam int GAIN_W     = 17;
   localparam int EPT_W      = 12;
   localparam int PROD_W     = MV_W + GAIN_W;
   localparam int FRAC_BITS  = 10;
   localparam int SUM_W      = PROD_W - FRAC_BITS + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_TICKS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CV_GAIN         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TICKS       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PULSE_TICKS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALLOW_RETRIGGER = 3'd4;

   localparam logic signed [MV_W-1:0] TRIG_FIRE_MV  = 15'sd2000;
   localparam logic signed [MV_W-1:0] TRIG_REARM_MV = 15'sd100;

   localparam logic [COUNT_BITS-1:0] GATE_COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [END_BITS-1:0]   END_COUNT_MAX  = {END_BITS{1'b1}};

   typedef struct packed {
      logic [TICK_W-1:0]        base_ticks;
      logic signed [GAIN_W-1:0] cv_gain;
      logic [TICK_W-1:0]        max_ticks;
      logic [EPT_W-1:0]         end_pulse_ticks;
      logic                     allow_retrigger;
   } cfg_type;

   typedef struct packed {
      logic [CH_W-1:0]        channel;
      logic signed [MV_W-1:0] trig_mv;
      logic signed [MV_W-1:0] cv_mv;
   } in_item_type;

   typedef struct packed {
      logic [CH_W-1:0]          channel;
      logic signed [MV_W-1:0]   trig_mv;
      logic signed [PROD_W-1:0] prod;
   } prod_item_type;

   typedef struct packed {
      logic [CH_W-1:0]        channel;
      logic signed [MV_W-1:0] trig_mv;
      logic [TICK_W-1:0]      len;
   } len_item_type;

endpackage

// ===== rtl/core/rgg_csr.sv =====
// Configuration registers written through the plain write port.
module rgg_csr
   import rgg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_BASE_TICKS:      cfg_in.base_ticks      = csr_wdata[TICK_W-1:0];
            CSR_CV_GAIN:         cfg_in.cv_gain         = signed'(csr_wdata[GAIN_W-1:0]);
            CSR_MAX_TICKS:       cfg_in.max_ticks       = csr_wdata[TICK_W-1:0];
            CSR_END_PULSE_TICKS: cfg_in.end_pulse_ticks = csr_wdata[EPT_W-1:0];
            CSR_ALLOW_RETRIGGER: cfg_in.allow_retrigger = csr_wdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_ticks      <= 20'd24000;
         cfg_ff.cv_gain         <= '0;
         cfg_ff.max_ticks       <= 20'd480000;
         cfg_ff.end_pulse_ticks <= 12'd48;
         cfg_ff.allow_retrigger <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/rgg_len.sv =====
// Two-stage gate length pipeline: modulation product, then floor, offset and clamp.
module rgg_len
   import rgg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         s_valid,
   input  in_item_type  s_item,
   output logic         s_ready,
   output logic         m_valid,
   output len_item_type m_item,
   input  logic         m_ready
);

   logic          p_v_ff;
   prod_item_type p_ff;
   prod_item_type p_in;
   logic          l_v_ff;
   len_item_type  l_ff;
   len_item_type  l_in;
   logic          p_ready;
   logic          l_ready;
   logic signed [SUM_W-1:0] sum;

   assign l_ready = !l_v_ff || m_ready;
   assign p_ready = !p_v_ff || l_ready;
   assign s_ready = p_ready;

   always_comb begin
      p_in.channel = s_item.channel;
      p_in.trig_mv = s_item.trig_mv;
      p_in.prod    = s_item.cv_mv * cfg.cv_gain;
   end

   // Dropping the fraction bits of a two's complement product rounds toward minus infinity.
   assign sum = {p_ff.prod[PROD_W-1], p_ff.prod[PROD_W-1:FRAC_BITS]}
              + signed'({{(SUM_W-TICK_W){1'b0}}, cfg.base_ticks});

   always_comb begin
      l_in.channel = p_ff.channel;
      l_in.trig_mv = p_ff.trig_mv;
      if (sum[SUM_W-1]) begin
         l_in.len = '0;
      end else if (sum[SUM_W-2:0] > {{(SUM_W-1-TICK_W){1'b0}}, cfg.max_ticks}) begin
         l_in.len = cfg.max_ticks;
      end else begin
         l_in.len = sum[TICK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
         l_v_ff <= 1'b0;
      end else begin
         if (p_ready) begin
            p_v_ff <= s_valid;
         end
         if (l_ready) begin
            l_v_ff <= p_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (p_ready && s_valid) begin
         p_ff <= p_in;
      end
      if (l_ready && p_v_ff) begin
         l_ff <= l_in;
      end
   end

   assign m_valid = l_v_ff;
   assign m_item  = l_ff;

endmodule

// ===== rtl/core/rgg_voice.sv =====
// Per-channel trigger qualifier, gate timer and end pulse timer with the result register.
module rgg_voice
   import rgg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            s_valid,
   input  len_item_type    s_item,
   output logic            s_ready,
   output logic            rsp_valid,
   output logic [CH_W-1:0] rsp_channel,
   output logic            rsp_gate_on,
   output logic            rsp_end_pulse_on,
   input  logic            rsp_ready
);

   logic                  armed_ff  [CHANNELS];
   logic [COUNT_BITS-1:0] gel_ff    [CHANNELS];
   logic                  gact_ff   [CHANNELS];
   logic                  eq_ff     [CHANNELS];
   logic [END_BITS-1:0]   eel_ff    [CHANNELS];
   logic                  eact_ff   [CHANNELS];

   logic                  armed_in;
   logic [COUNT_BITS-1:0] gel_in;
   logic                  gact_in;
   logic                  eq_in;
   logic [END_BITS-1:0]   eel_in;
   logic                  eact_in;

   logic                  fired;
   logic                  start;
   logic [COUNT_BITS-1:0] gel_mid;
   logic                  gact_mid;
   logic                  eact_mid;
   logic [END_BITS-1:0]   eel_mid;

   logic                  rsp_v_ff;
   logic [CH_W-1:0]       rsp_ch_ff;
   logic                  rsp_gate_ff;
   logic                  rsp_end_ff;
   logic                  take;

   assign s_ready = !rsp_v_ff || rsp_ready;
   assign take    = s_valid && s_ready;

   always_comb begin
      fired    = 1'b0;
      armed_in = armed_ff[s_item.channel];
      if (armed_ff[s_item.channel]) begin
         if (s_item.trig_mv <= TRIG_REARM_MV) begin
            armed_in = 1'b0;
         end
      end else if (s_item.trig_mv >= TRIG_FIRE_MV) begin
         armed_in = 1'b1;
         fired    = 1'b1;
      end

      start = fired && (s_item.len != '0)
            && (!gact_ff[s_item.channel] || cfg.allow_retrigger);
      gel_mid  = start ? '0 : gel_ff[s_item.channel];
      gact_mid = start || gact_ff[s_item.channel];
      gel_in   = (gel_mid != GATE_COUNT_MAX) ? gel_mid + 1'b1 : gel_mid;
      gact_in  = gact_mid
               && !(gel_in >= {{(COUNT_BITS-TICK_W){1'b0}}, s_item.len});

      // The end qualifier watches the inverted gate and fires when the gate falls.
      eq_in    = eq_ff[s_item.channel];
      eel_mid  = eel_ff[s_item.channel];
      eact_mid = eact_ff[s_item.channel];
      if (eq_ff[s_item.channel]) begin
         if (gact_in) begin
            eq_in = 1'b0;
         end
      end else if (!gact_in) begin
         eq_in    = 1'b1;
         eel_mid  = '0;
         eact_mid = 1'b1;
      end
      eel_in  = (eel_mid != END_COUNT_MAX) ? eel_mid + 1'b1 : eel_mid;
      eact_in = eact_mid
              && !(eel_in >= {{(END_BITS-EPT_W){1'b0}}, cfg.end_pulse_ticks});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            armed_ff[i] <= 1'b1;
            gel_ff[i]   <= '0;
            gact_ff[i]  <= 1'b0;
            eq_ff[i]    <= 1'b1;
            eel_ff[i]   <= '0;
            eact_ff[i]  <= 1'b0;
         end
      end else if (take) begin
         armed_ff[s_item.channel] <= armed_in;
         gel_ff[s_item.channel]   <= gel_in;
         gact_ff[s_item.channel]  <= gact_in;
         eq_ff[s_item.channel]    <= eq_in;
         eel_ff[s_item.channel]   <= eel_in;
         eact_ff[s_item.channel]  <= eact_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (s_ready) begin
         rsp_v_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ch_ff   <= s_item.channel;
         rsp_gate_ff <= gact_in;
         rsp_end_ff  <= eact_in;
      end
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_channel      = rsp_ch_ff;
   assign rsp_gate_on      = rsp_gate_ff;
   assign rsp_end_pulse_on = rsp_end_ff;

endmodule

// ===== rtl/core/poly_retriggerable_gate_generator.sv =====
// Top level of the polyphonic retriggerable gate generator.
// A word passes the input, product, length and result registers in that order.
// Throughput: one word per cycle while rsp_tready is high; each stage holds one word and
// refills as its successor drains. The per-channel state is read and written back in the voice
// stage, so words of one channel may follow each other back to back.
// Reset (synchronous, active high) empties the pipeline and restores registers and channel state.
module poly_retriggerable_gate_generator
   import rgg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [3:0] channel, [18:4] trig_mv, [33:19] cv_mv, [39:34] zero
   input  logic [39:0]           req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] out_channel, [4] gate_on, [5] end_pulse_on, [7:6] zero
   output logic [7:0]            rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   logic         in_v_ff;
   in_item_type  in_ff;
   in_item_type  in_in;
   logic         len_s_ready;
   logic         len_valid;
   len_item_type len_item;
   logic         voice_ready;
   logic [CH_W-1:0] out_channel;
   logic         gate_on;
   logic         end_pulse_on;

   rgg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign req_tready = !in_v_ff || len_s_ready;

   always_comb begin
      in_in.channel = req_tdata[3:0];
      in_in.trig_mv = signed'(req_tdata[18:4]);
      in_in.cv_mv   = signed'(req_tdata[33:19]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (req_tready) begin
         in_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff <= in_in;
      end
   end

   rgg_len u_len (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .s_valid (in_v_ff),
      .s_item  (in_ff),
      .s_ready (len_s_ready),
      .m_valid (len_valid),
      .m_item  (len_item),
      .m_ready (voice_ready)
   );

   rgg_voice u_voice (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .s_valid          (len_valid),
      .s_item           (len_item),
      .s_ready          (voice_ready),
      .rsp_valid        (rsp_tvalid),
      .rsp_channel      (out_channel),
      .rsp_gate_on      (gate_on),
      .rsp_end_pulse_on (end_pulse_on),
      .rsp_ready        (rsp_tready)
   );

   assign rsp_tdata = {2'b00, end_pulse_on, gate_on, out_channel};

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the polyphonic retriggerable gate generator.
module tb_top
   import rgg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES      = 8;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int RUN_LIMIT_NS      = 2_000_000;

   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic [TICK_W-1:0]        TICK_TOP = {TICK_W{1'b1}};
   localparam logic [EPT_W-1:0]         EPT_TOP  = {EPT_W{1'b1}};

   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic            gate_on;
      logic            end_pulse_on;
   } pulse_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stalls_asked = 0;
   int stalls_granted = 0;
   int stall_left = 0;
   int mismatch_count = 0;

   pulse_word_type expected_words [$];

   cfg_type               gate_cfg;
   logic                  trig_armed   [CHANNELS];
   logic [COUNT_BITS-1:0] gate_count   [CHANNELS];
   logic                  gate_running [CHANNELS];
   logic                  end_armed    [CHANNELS];
   logic [END_BITS-1:0]   end_count    [CHANNELS];
   logic                  end_running  [CHANNELS];

   poly_retriggerable_gate_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic reset_gate_model();
      gate_cfg.base_ticks      = TICK_W'(24000);
      gate_cfg.cv_gain         = '0;
      gate_cfg.max_ticks       = TICK_W'(480000);
      gate_cfg.end_pulse_ticks = EPT_W'(48);
      gate_cfg.allow_retrigger = 1'b1;
      for (int c = 0; c < CHANNELS; c++) begin
         trig_armed[c]   = 1'b1;
         gate_count[c]   = '0;
         gate_running[c] = 1'b0;
         end_armed[c]    = 1'b1;
         end_count[c]    = '0;
         end_running[c]  = 1'b0;
      end
   endtask

   function automatic logic [TICK_W-1:0] gate_span(input logic signed [MV_W-1:0] cv);
      longint product;
      longint ticks;
      product = longint'(cv) * longint'(gate_cfg.cv_gain);
      ticks = longint'(gate_cfg.base_ticks) + (product >>> FRAC_BITS);
      if (ticks < 0) ticks = 0;
      if (ticks > longint'(gate_cfg.max_ticks)) ticks = longint'(gate_cfg.max_ticks);
      return ticks[TICK_W-1:0];
   endfunction

   function automatic pulse_word_type advance_gate_model(input logic [CH_W-1:0] ch,
         input logic signed [MV_W-1:0] trig, input logic signed [MV_W-1:0] cv);
      pulse_word_type word;
      logic [TICK_W-1:0] span;
      logic fired;
      span = gate_span(cv);
      fired = 1'b0;
      if (trig_armed[ch]) begin
         if (trig <= TRIG_REARM_MV) trig_armed[ch] = 1'b0;
      end else if (trig >= TRIG_FIRE_MV) begin
         trig_armed[ch] = 1'b1;
         fired = 1'b1;
      end
      if (fired && span != '0 && (!gate_running[ch] || gate_cfg.allow_retrigger)) begin
         gate_count[ch] = '0;
         gate_running[ch] = 1'b1;
      end
      if (gate_count[ch] != GATE_COUNT_MAX) gate_count[ch] = gate_count[ch] + 1'b1;
      if (gate_running[ch] && gate_count[ch] >= COUNT_BITS'(span)) gate_running[ch] = 1'b0;
      if (end_armed[ch]) begin
         if (gate_running[ch]) end_armed[ch] = 1'b0;
      end else if (!gate_running[ch]) begin
         end_armed[ch] = 1'b1;
         end_count[ch] = '0;
         end_running[ch] = 1'b1;
      end
      if (end_count[ch] != END_COUNT_MAX) end_count[ch] = end_count[ch] + 1'b1;
      if (end_running[ch] && end_count[ch] >= END_BITS'(gate_cfg.end_pulse_ticks)) begin
         end_running[ch] = 1'b0;
      end
      word.channel = ch;
      word.gate_on = gate_running[ch];
      word.end_pulse_on = end_running[ch];
      return word;
   endfunction

   task automatic send_tick(input logic [CH_W-1:0] ch, input logic signed [MV_W-1:0] trig,
         input logic signed [MV_W-1:0] cv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cv, trig, ch};
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(advance_gate_model(ch, trig, cv));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_BASE_TICKS:      gate_cfg.base_ticks = value[TICK_W-1:0];
         CSR_CV_GAIN:         gate_cfg.cv_gain = value[GAIN_W-1:0];
         CSR_MAX_TICKS:       gate_cfg.max_ticks = value[TICK_W-1:0];
         CSR_END_PULSE_TICKS: gate_cfg.end_pulse_ticks = value[EPT_W-1:0];
         CSR_ALLOW_RETRIGGER: gate_cfg.allow_retrigger = value[0];
         default: ;
      endcase
   endtask

   // Unused upper bits carry noise so that register masking is exercised, and every
   // update ends with a write to an unmapped index that must be ignored.
   task automatic configure(input logic [TICK_W-1:0] base, input logic signed [GAIN_W-1:0] gain,
         input logic [TICK_W-1:0] limit, input logic [EPT_W-1:0] end_len, input logic retrig);
      logic [31:0] junk;
      wait_idle();
      junk = $urandom;
      write_csr(CSR_BASE_TICKS, base);
      write_csr(CSR_CV_GAIN, {junk[CSR_DATA_W-GAIN_W-1:0], gain});
      write_csr(CSR_MAX_TICKS, limit);
      write_csr(CSR_END_PULSE_TICKS, {junk[CSR_DATA_W-EPT_W-1:0], end_len});
      write_csr(CSR_ALLOW_RETRIGGER, {junk[CSR_DATA_W-2:0], retrig});
      write_csr(CSR_IDX_W'($urandom_range(int'(CSR_ALLOW_RETRIGGER) + 1, (1 << CSR_IDX_W) - 1)),
         CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   task automatic configure_random();
      logic [TICK_W-1:0] base;
      logic signed [GAIN_W-1:0] gain;
      logic [TICK_W-1:0] limit;
      logic [EPT_W-1:0] end_len;
      base = TICK_W'($urandom_range(0, 12));
      case ($urandom_range(0, 4))
         0: gain = '0;
         1: gain = GAIN_MIN;
         2: gain = GAIN_MAX;
         3: gain = GAIN_W'($urandom);
         default: gain = GAIN_W'(int'($urandom_range(0, 31)) - 16);
      endcase
      limit = ($urandom_range(0, 4) == 0) ? TICK_TOP : TICK_W'($urandom_range(0, 20));
      end_len = ($urandom_range(0, 4) == 0) ? EPT_TOP : EPT_W'($urandom_range(0, 6));
      configure(base, gain, limit, end_len, 1'($urandom_range(0, 1)));
   endtask

   task automatic test_reset_defaults();
      send_tick(0, 0, 0);
      send_tick(0, 2000, 0);
      send_tick(0, 16383, -16384);
      send_tick(0, -16384, 16383);
      send_tick(15, 100, 0);
   endtask

   task automatic test_schmitt_and_retrigger();
      configure(3, 0, 8, 2, 1'b0);
      send_tick(1, 101, 0);
      send_tick(1, 2000, 0);
      send_tick(1, 100, 0);
      send_tick(1, 1999, 0);
      send_tick(1, 2000, 0);
      send_tick(1, 0, 0);
      send_tick(1, 2000, 0);
      send_tick(1, 0, 0);
      configure(3, 0, 8, 2, 1'b1);
      send_tick(1, 2000, 0);
      send_tick(1, 0, 0);
      send_tick(1, 2000, 0);
   endtask

   task automatic test_zero_length_and_shrink();
      configure(0, 0, 10, 0, 1'b1);
      send_tick(2, 0, 0);
      send_tick(2, 2000, 0);
      configure(6, 17'sd1024, 10, 0, 1'b1);
      send_tick(2, 0, 0);
      send_tick(2, 2000, 0);
      send_tick(2, 2000, -5);
      send_tick(2, 0, -16384);
   endtask

   task automatic test_register_extremes();
      configure(TICK_TOP, GAIN_MIN, TICK_TOP, EPT_TOP, 1'b0);
      send_tick(3, 0, 16383);
      send_tick(3, 2000, -1);
      configure(TICK_TOP, GAIN_MAX, 0, 1, 1'b1);
      send_tick(3, 0, 0);
      send_tick(3, 2000, 0);
   endtask

   // Most words sit on a few busy channels with trigger levels at or below the re-arm
   // or at or above the fire threshold, so that gates and end pulses run through whole cycles.
   task automatic test_random_ticks(input int count);
      logic [CH_W-1:0] ch;
      logic signed [MV_W-1:0] trig;
      logic signed [MV_W-1:0] cv;
      for (int n = 0; n < count; n++) begin
         ch = ($urandom_range(0, 9) < 8) ? CH_W'($urandom_range(0, 3))
                                         : CH_W'($urandom_range(0, CHANNELS - 1));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: trig = MV_W'(int'($urandom_range(0, 16484)) - 16384);
            4, 5, 6, 7: trig = MV_W'($urandom_range(2000, 16383));
            8: trig = MV_W'($urandom_range(101, 1999));
            default: trig = MV_W'($urandom);
         endcase
         cv = ($urandom_range(0, 9) < 7) ? MV_W'(int'($urandom_range(0, 4095)) - 2048)
                                         : MV_W'($urandom);
         send_tick(ch, trig, cv);
      end
   endtask

   task automatic test_backpressure();
      configure_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stalls_asked <= stalls_asked + 1;
      test_random_ticks(40);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_granted != stalls_asked) begin
         rsp_tready <= 1'b0;
         stall_left <= LONG_STALL_CYCLES;
         stalls_granted <= stalls_granted + 1;
      end else begin
         rsp_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pulse_word_type want;
      pulse_word_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.channel = rsp_tdata[CH_W-1:0];
         got.gate_on = rsp_tdata[CH_W];
         got.end_pulse_on = rsp_tdata[CH_W+1];
         if (expected_words.size() == 0) begin
            $error("unexpected result word on channel %0d", got.channel);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (got.channel !== want.channel) begin
               $error("out_channel: expected %0d, actual %0d", want.channel, got.channel);
               mismatch_count++;
            end
            if (got.gate_on !== want.gate_on) begin
               $error("gate_on: expected %0d, actual %0d", want.gate_on, got.gate_on);
               mismatch_count++;
            end
            if (got.end_pulse_on !== want.end_pulse_on) begin
               $error("end_pulse_on: expected %0d, actual %0d", want.end_pulse_on,
                  got.end_pulse_on);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset_gate_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_schmitt_and_retrigger();
      test_zero_length_and_shrink();
      test_register_extremes();
      send_idle_pct = 29;
      recv_idle_pct = 75;
      repeat (2) begin
         configure_random();
         test_random_ticks(125);
      end
      send_idle_pct = 75;
      recv_idle_pct = 29;
      repeat (2) begin
         configure_random();
         test_random_ticks(125);
      end
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) begin
         configure_random();
         test_random_ticks(125);
      end
      test_backpressure();
      wait_idle();
      if (mismatch_count == 0) begin
         $display("** poly_retriggerable_gate_generator: PASSED **");
      end else begin
         $display("** poly_retriggerable_gate_generator: FAILED **");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("** poly_retriggerable_gate_generator: FAILED **");
      $finish;
   end

endmodule

// ===== poly_retriggerable_gate_generator.f =====
rtl/core/rgg_pkg.sv
rtl/core/rgg_csr.sv
rtl/core/rgg_len.sv
rtl/core/rgg_voice.sv
rtl/core/poly_retriggerable_gate_generator.sv
sim/tb_top.sv
